[rtl/fqr_pkg.sv]
// Shared types and field widths for the id queue with search and remove.
`timescale 1ns / 1ps
`default_nettype none
package fqr_pkg;

  localparam int FuncW   = 2;
  localparam int IdFldW  = 16;
  localparam int PosFldW = 4;
  localparam int CntFldW = 5;

  typedef enum logic [FuncW-1:0] {
    FN_APPEND = 2'd0,
    FN_POP    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_QUERY  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    status_e              status;
    logic [IdFldW-1:0]    out_id;
    logic [PosFldW-1:0]   position;
    logic [CntFldW-1:0]   entry_count;
  } rsp_t;

endpackage
`default_nettype wire

[rtl/fqr_if.sv]
// Valid/ready channel interfaces for request and response items.
`timescale 1ns / 1ps
`default_nettype none
interface fqr_req_if;
  logic                          valid;
  logic                          ready;
  fqr_pkg::func_e                func;
  logic [fqr_pkg::IdFldW-1:0]    entry_id;

  modport source (output valid, func, entry_id, input ready);
  modport sink   (input valid, func, entry_id, output ready);
endinterface

interface fqr_rsp_if;
  logic                          valid;
  logic                          ready;
  fqr_pkg::status_e              status;
  logic [fqr_pkg::IdFldW-1:0]    out_id;
  logic [fqr_pkg::PosFldW-1:0]   position;
  logic [fqr_pkg::CntFldW-1:0]   entry_count;

  modport source (output valid, status, out_id, position, entry_count, input ready);
  modport sink   (input valid, status, out_id, position, entry_count, output ready);
endinterface
`default_nettype wire

[rtl/fqr_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fqr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/fifo_queue_with_remove_by_id_unit.sv]
// Top level: ordered id queue with append, pop, remove by id and position query.
`timescale 1ns / 1ps
`default_nettype none
// The queue keeps up to DEPTH ids in one RAM, oldest at address zero, and
// serves one request item at a time. Pop, remove and query walk the RAM
// through its single read port, one entry per cycle, and a pop or remove
// then closes the gap by copying each later entry down one address, one
// per cycle, read then write back. The entries searched and the entries
// moved never add up to more than the fill level. A finished result sits
// in an output register, so the next request is taken while the previous
// result still waits. Every request gives exactly one result; entry_count
// is the fill level after the operation.
module fifo_queue_with_remove_by_id_unit #(
  parameter int DEPTH    = 16,
  parameter int ID_WIDTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fqr_req_if.sink    req_i,
  fqr_rsp_if.source  rsp_o
);
  import fqr_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int XIW = (ID_WIDTH > IdFldW) ? ID_WIDTH : IdFldW;
  localparam int XPW = (AW > PosFldW) ? AW : PosFldW;
  localparam int XCW = (CW > CntFldW) ? CW : CntFldW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [AW-1:0]       rd_idx_q, rd_idx_d;
  logic                rd_pend_q, rd_pend_d;
  func_e               op_q, op_d;
  logic [ID_WIDTH-1:0] id_q, id_d;
  status_e             res_st_q, res_st_d;
  logic [ID_WIDTH-1:0] res_id_q, res_id_d;
  logic [AW-1:0]       res_pos_q, res_pos_d;
  logic                out_vld_q, out_vld_d;
  rsp_t                out_q, out_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ID_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [ID_WIDTH-1:0] ram_rdata;

  logic [XIW-1:0]      in_id_x;
  logic [ID_WIDTH-1:0] in_id;
  logic [XIW-1:0]      res_id_x;
  logic [XPW-1:0]      res_pos_x;
  logic [XCW-1:0]      cnt_x;
  logic                hit;

  fqr_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Fit the fixed-width fields to the configured widths.
  assign in_id_x   = XIW'(req_i.entry_id);
  assign in_id     = in_id_x[ID_WIDTH-1:0];
  assign res_id_x  = XIW'(res_id_q);
  assign res_pos_x = XPW'(res_pos_q);
  assign cnt_x     = XCW'(cnt_q);

  assign hit = rd_pend_q && ((op_q == FN_POP) || (ram_rdata == id_q));

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.out_id      = out_q.out_id;
  assign rsp_o.position    = out_q.position;
  assign rsp_o.entry_count = out_q.entry_count;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    rd_idx_d  = rd_idx_q;
    rd_pend_d = rd_pend_q;
    op_d      = op_q;
    id_d      = id_q;
    res_st_d  = res_st_q;
    res_id_d  = res_id_q;
    res_pos_d = res_pos_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_waddr = rd_idx_q - AW'(1);
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d      = req_i.func;
          id_d      = in_id;
          idx_d     = '0;
          rd_pend_d = 1'b0;
          res_id_d  = '0;
          res_pos_d = '0;
          res_st_d  = ST_MISS;
          if (req_i.func == FN_APPEND) begin
            if (cnt_q == CW'(DEPTH)) begin
              res_st_d = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt_q[AW-1:0];
              ram_wdata = in_id;
              cnt_d     = cnt_q + CW'(1);
              res_st_d  = ST_OK;
            end
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          res_st_d = ST_OK;
          if (op_q == FN_QUERY) begin
            res_pos_d = rd_idx_q;
            state_d   = S_DONE;
          end else begin
            // close the gap behind the match
            res_id_d  = ram_rdata;
            idx_d     = CW'(rd_idx_q) + CW'(1);
            rd_pend_d = 1'b0;
            state_d   = S_SHIFT;
          end
        end else if (idx_q < cnt_q) begin
          rd_idx_d  = idx_q[AW-1:0];
          rd_pend_d = 1'b1;
          idx_d     = idx_q + CW'(1);
        end else if (rd_pend_q) begin
          rd_pend_d = 1'b0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        // write back the entry read last cycle one address lower
        if (rd_pend_q) begin
          ram_we = 1'b1;
        end
        if (idx_q < cnt_q) begin
          rd_idx_d  = idx_q[AW-1:0];
          rd_pend_d = 1'b1;
          idx_d     = idx_q + CW'(1);
        end else if (rd_pend_q) begin
          rd_pend_d = 1'b0;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_d.status      = res_st_q;
          out_d.out_id      = res_id_x[IdFldW-1:0];
          out_d.position    = res_pos_x[PosFldW-1:0];
          out_d.entry_count = cnt_x[CntFldW-1:0];
          out_vld_d         = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    rd_idx_q  <= rd_idx_d;
    op_q      <= op_d;
    id_q      <= id_d;
    res_st_q  <= res_st_d;
    res_id_q  <= res_id_d;
    res_pos_q <= res_pos_d;
    out_q     <= out_d;
  end

endmodule
`default_nettype wire
